// File: rtl/mld_pkg.sv
// ----------------------------------------------------------------------------
// Marker length deframer package
// Shared widths, phase codes, result kinds and the sync marker table.
// ----------------------------------------------------------------------------
package mld_pkg;

  localparam int LENGTH_BITS   = 16;
  localparam int MARKER_LEN    = 6;
  localparam int LEN_BYTES     = (LENGTH_BITS + 7) / 8;
  localparam int HDR_BYTES     = MARKER_LEN + LEN_BYTES;
  localparam int TRAILER_BYTES = 2;
  localparam int MIN_FRAME     = HDR_BYTES + TRAILER_BYTES;
  localparam int BLOCK_BITS    = 4;

  typedef logic [LENGTH_BITS-1:0] len_t;
  typedef logic [2:0]             match_t;
  typedef logic [1:0]             phase_t;
  typedef logic [1:0]             kind_t;

  localparam phase_t PH_HUNT    = 2'd0;
  localparam phase_t PH_LENGTH  = 2'd1;
  localparam phase_t PH_PAYLOAD = 2'd2;
  localparam phase_t PH_TRAILER = 2'd3;

  localparam kind_t KIND_PAYLOAD    = 2'd0;
  localparam kind_t KIND_LAST       = 2'd1;
  localparam kind_t KIND_EMPTY      = 2'd2;
  localparam kind_t KIND_BAD_LENGTH = 2'd3;

  localparam len_t   MIN_FRAME_LEN  = len_t'(MIN_FRAME);
  localparam len_t   LEN_BYTES_LEN  = len_t'(LEN_BYTES);
  localparam len_t   TRAILER_LEN    = len_t'(TRAILER_BYTES);
  localparam match_t MARKER_LEN_M   = match_t'(MARKER_LEN);

  function automatic logic [7:0] marker_byte(input match_t idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h24;
      3'd1:    b = 8'h49;
      3'd2:    b = 8'h44;
      3'd3:    b = 8'h53;
      3'd4:    b = 8'h53;
      3'd5:    b = 8'h45;
      default: b = 8'h24;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/marker_length_deframer_unit.sv
// ----------------------------------------------------------------------------
// Marker length deframer unit
// Hunts for the sync marker, reads the big-endian frame length, emits the
// payload bytes, reports empty and too-short frames, and skips the trailer.
// ----------------------------------------------------------------------------
//   Channel | Direction | Handshake               | Beat fields
//   in      | input     | in_valid_i, in_stall_o  | data_byte_i
//   out     | output    | out_valid_o, out_stall_i| payload_byte_o, result_kind_o,
//           |           |                         | block_aligned_o
//
// One byte can be accepted every cycle while the output is not stalled;
// a beat passes through the input register and then the result register.
// The input register advances whenever the result register is empty or is
// being taken, so a stall on the output reaches the input in the same cycle.
// Reset clears the valid flags and returns the deframer to marker hunting.
module marker_length_deframer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] payload_byte_o,
  output logic [1:0] result_kind_o,
  output logic       block_aligned_o
);

  logic                in_valid_q;
  logic [7:0]          in_byte_q;
  logic                advance;

  mld_pkg::phase_t     phase_q, phase_d;
  mld_pkg::match_t     matched_q, matched_d;
  mld_pkg::len_t       frame_len_q, frame_len_d;
  mld_pkg::len_t       position_q, position_d;

  logic                res_valid;
  logic [7:0]          res_byte;
  mld_pkg::kind_t      res_kind;
  logic                res_aligned;

  logic                out_valid_q;
  logic [7:0]          out_byte_q;
  mld_pkg::kind_t      out_kind_q;
  logic                out_aligned_q;

  mld_pkg::len_t       pos_inc;
  mld_pkg::len_t       payload_count;
  mld_pkg::len_t       shifted_len;
  mld_pkg::match_t     match_base;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= data_byte_i;
    end
  end

  assign pos_inc       = position_q + 1'b1;
  assign payload_count = frame_len_q - mld_pkg::MIN_FRAME_LEN;
  assign shifted_len   = mld_pkg::len_t'({frame_len_q, in_byte_q});
  assign match_base    = (matched_q >= mld_pkg::MARKER_LEN_M) ? 3'd0 : matched_q;

  always_comb begin
    phase_d     = phase_q;
    matched_d   = matched_q;
    frame_len_d = frame_len_q;
    position_d  = position_q;
    res_valid   = 1'b0;
    res_byte    = 8'd0;
    res_kind    = mld_pkg::KIND_PAYLOAD;
    res_aligned = 1'b0;
    unique case (phase_q)
      mld_pkg::PH_LENGTH: begin
        frame_len_d = shifted_len;
        position_d  = pos_inc;
        if (pos_inc >= mld_pkg::LEN_BYTES_LEN) begin
          position_d = '0;
          if (shifted_len < mld_pkg::MIN_FRAME_LEN) begin
            phase_d   = mld_pkg::PH_HUNT;
            res_valid = 1'b1;
            res_kind  = mld_pkg::KIND_BAD_LENGTH;
          end else if (shifted_len == mld_pkg::MIN_FRAME_LEN) begin
            phase_d     = mld_pkg::PH_TRAILER;
            res_valid   = 1'b1;
            res_kind    = mld_pkg::KIND_EMPTY;
            res_aligned = 1'b1;
          end else begin
            phase_d = mld_pkg::PH_PAYLOAD;
          end
        end
      end
      mld_pkg::PH_PAYLOAD: begin
        position_d = pos_inc;
        res_valid  = 1'b1;
        res_byte   = in_byte_q;
        if (pos_inc >= payload_count) begin
          position_d  = '0;
          phase_d     = mld_pkg::PH_TRAILER;
          res_kind    = mld_pkg::KIND_LAST;
          res_aligned = (payload_count[mld_pkg::BLOCK_BITS-1:0] == '0);
        end
      end
      mld_pkg::PH_TRAILER: begin
        position_d = pos_inc;
        if (pos_inc >= mld_pkg::TRAILER_LEN) begin
          position_d = '0;
          phase_d    = mld_pkg::PH_HUNT;
        end
      end
      mld_pkg::PH_HUNT: begin
        if (in_byte_q == mld_pkg::marker_byte(match_base)) begin
          matched_d = match_base + 1'b1;
        end else begin
          matched_d = (in_byte_q == mld_pkg::marker_byte(3'd0)) ? 3'd1 : 3'd0;
        end
        if (matched_d == mld_pkg::MARKER_LEN_M) begin
          matched_d   = '0;
          frame_len_d = '0;
          position_d  = '0;
          phase_d     = mld_pkg::PH_LENGTH;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= mld_pkg::PH_HUNT;
      matched_q   <= '0;
      frame_len_q <= '0;
      position_q  <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && res_valid;
      if (in_valid_q) begin
        phase_q     <= phase_d;
        matched_q   <= matched_d;
        frame_len_q <= frame_len_d;
        position_q  <= position_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && res_valid) begin
      out_byte_q    <= res_byte;
      out_kind_q    <= res_kind;
      out_aligned_q <= res_aligned;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_byte_o  = out_byte_q;
  assign result_kind_o   = out_kind_q;
  assign block_aligned_o = out_aligned_q;

endmodule
